>>> hw/rtl/tanq_pkg.sv
// Package for the telemetry anomaly qualifier.
// Holds widths, register and event codes, the event and qualifier types and the
// qualifier update function; no dependencies.
`default_nettype none
package tanq_pkg;

	localparam int TIME_BITS   = 48;
	localparam int BYTE_BITS   = 48;
	localparam int WALL_BITS   = 48;
	localparam int VALUE_BITS  = 48;
	localparam int LOAD_BITS   = 10;
	localparam int COUNT_BITS  = 8;
	localparam int DELAY_BITS  = 16;
	localparam int MEM_SCALE   = 1000;
	localparam int TOTAL_BITS  = BYTE_BITS + 1;
	localparam int PROD_BITS   = BYTE_BITS + LOAD_BITS;
	localparam int REM_BITS    = BYTE_BITS + 2;
	localparam int STEP_BITS   = $clog2(PROD_BITS);
	localparam int PADDR_BITS  = 4;
	localparam int PDATA_BITS  = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [LOAD_BITS-1:0]  CPU_LIMIT_RST   = LOAD_BITS'(900);
	localparam logic [LOAD_BITS-1:0]  MEM_LIMIT_RST   = LOAD_BITS'(900);
	localparam logic [COUNT_BITS-1:0] CONFIRM_RST     = COUNT_BITS'(3);
	localparam logic [DELAY_BITS-1:0] DELAY_LIMIT_RST = DELAY_BITS'(1500);

	typedef enum logic [1:0] {
		REG_CPU_LIMIT,
		REG_MEM_LIMIT,
		REG_CONFIRM,
		REG_DELAY_LIMIT
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_CPU,
		KIND_MEM,
		KIND_DELAY
	} kind_t;

	typedef enum logic [1:0] {
		PH_STARTED,
		PH_STOPPED,
		PH_OCCURRED
	} phase_t;

	typedef struct packed {
		logic [LOAD_BITS-1:0]  cpu_limit;
		logic [LOAD_BITS-1:0]  mem_limit;
		logic [COUNT_BITS-1:0] confirm;
		logic [DELAY_BITS-1:0] delay_limit;
	} cfg_t;

	typedef struct packed {
		kind_t                 kind;
		phase_t                phase;
		logic [TIME_BITS-1:0]  time_ms;
		logic [WALL_BITS-1:0]  wall_ms;
		logic [VALUE_BITS-1:0] value;
		logic                  last;
	} event_t;

	typedef struct packed {
		logic                  active;
		logic [COUNT_BITS-1:0] count;
		logic [TIME_BITS-1:0]  run_time;
		logic [WALL_BITS-1:0]  run_wall;
		logic [LOAD_BITS-1:0]  run_value;
	} qual_t;

	typedef struct packed {
		qual_t st;
		logic  fire;
	} qual_res_t;

	function automatic qual_res_t qual_step(
		input qual_t                 s,
		input logic                  high,
		input logic [LOAD_BITS-1:0]  value,
		input logic [TIME_BITS-1:0]  t,
		input logic [WALL_BITS-1:0]  wall,
		input logic [COUNT_BITS-1:0] confirm
	);
		qual_res_t             r;
		logic [COUNT_BITS-1:0] cnt;
		r      = '{st: s, fire: 1'b0};
		cnt    = s.count + COUNT_BITS'(1);
		if (s.active != high) begin
			if (s.count == '0) begin
				r.st.run_time  = t;
				r.st.run_wall  = wall;
				r.st.run_value = value;
			end
			if (cnt >= confirm) begin
				r.st.active = !s.active;
				r.st.count  = '0;
				r.fire      = 1'b1;
			end else begin
				r.st.count = cnt;
			end
		end else begin
			r.st.count = '0;
		end
		return r;
	endfunction

	function automatic event_t qual_event(input kind_t kind, input qual_t s);
		event_t e;
		e.kind    = kind;
		e.phase   = s.active ? PH_STARTED : PH_STOPPED;
		e.time_ms = s.run_time;
		e.wall_ms = s.run_wall;
		e.value   = VALUE_BITS'(s.run_value);
		e.last    = 1'b0;
		return e;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tanq_div.sv
// Bit-serial restoring divider for memory load: floor(1000*used/(used+free)).
// One quotient bit per cycle; uses tanq_pkg.
`default_nettype none
module tanq_div (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire  [tanq_pkg::BYTE_BITS-1:0]  used,
	input  wire  [tanq_pkg::BYTE_BITS-1:0]  free,
	output logic                            done,
	output logic [tanq_pkg::LOAD_BITS-1:0]  load
);
	import tanq_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [PROD_BITS-1:0]  dvd_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [LOAD_BITS-1:0]  quo_q;
	logic                  zero_q;
	logic [TOTAL_BITS-1:0] total_in;
	logic [REM_BITS-1:0]   rem_sh;
	logic                  take;

	assign total_in = TOTAL_BITS'(used) + TOTAL_BITS'(free);
	assign rem_sh   = {rem_q[REM_BITS-2:0], dvd_q[PROD_BITS-1]};
	assign take     = rem_sh >= REM_BITS'(total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(PROD_BITS - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_BITS'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q   <= PROD_BITS'(used) * PROD_BITS'(MEM_SCALE);
			rem_q   <= '0;
			quo_q   <= '0;
			total_q <= total_in;
			zero_q  <= total_in == '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PROD_BITS-2:0], 1'b0};
			rem_q <= take ? rem_sh - REM_BITS'(total_q) : rem_sh;
			quo_q <= {quo_q[LOAD_BITS-2:0], take};
		end
	end

	assign done = done_q;
	assign load = zero_q ? '0 : quo_q;

endmodule
`default_nettype wire

>>> hw/rtl/tanq_front.sv
// Front end: accepts samples, runs the memory load divider, updates both
// qualifiers and the gap check, and pushes up to three events into the queue.
// Uses tanq_pkg and tanq_div.
`default_nettype none
module tanq_front (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire tanq_pkg::cfg_t             cfg,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire  [tanq_pkg::LOAD_BITS-1:0]  cpu_tenths,
	input  wire  [tanq_pkg::BYTE_BITS-1:0]  mem_used_bytes,
	input  wire  [tanq_pkg::BYTE_BITS-1:0]  mem_free_bytes,
	input  wire  [tanq_pkg::TIME_BITS-1:0]  sample_time_ms,
	input  wire  [tanq_pkg::WALL_BITS-1:0]  wall_time_ms,
	output logic                            push,
	output tanq_pkg::event_t                push_data,
	input  wire                             full
);
	import tanq_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_QUAL, ST_PUSH} state_t;

	state_t               state_q;
	logic [2:0]           pend_q;
	qual_t                cpu_st_q;
	qual_t                mem_st_q;
	logic [TIME_BITS-1:0] prev_q;
	logic                 have_prev_q;
	logic [LOAD_BITS-1:0] cpu_q;
	logic [TIME_BITS-1:0] time_q;
	logic [WALL_BITS-1:0] wall_q;
	event_t               ev_q [3];

	logic                 accept;
	logic                 div_done;
	logic [LOAD_BITS-1:0] mem_load;
	qual_res_t            cpu_res;
	qual_res_t            mem_res;
	logic [TIME_BITS-1:0] gap;
	logic                 gap_fire;
	event_t               gap_ev;
	logic [2:0]           sel_oh;
	logic [2:0]           rest;

	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && !in_stall;

	tanq_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.used  (mem_used_bytes),
		.free  (mem_free_bytes),
		.done  (div_done),
		.load  (mem_load)
	);

	always_comb begin
		cpu_res = qual_step(cpu_st_q, cpu_q >= cfg.cpu_limit, cpu_q, time_q, wall_q,
			cfg.confirm);
		mem_res = qual_step(mem_st_q, mem_load >= cfg.mem_limit, mem_load, time_q,
			wall_q, cfg.confirm);
		gap      = time_q - prev_q;
		gap_fire = have_prev_q && (gap > TIME_BITS'(cfg.delay_limit));
		gap_ev   = '{kind: KIND_DELAY, phase: PH_OCCURRED, time_ms: time_q,
			wall_ms: wall_q, value: VALUE_BITS'(gap), last: 1'b0};
	end

	always_comb begin
		priority if (pend_q[0]) sel_oh = 3'b001;
		else if (pend_q[1])     sel_oh = 3'b010;
		else                    sel_oh = 3'b100;
		rest = pend_q & ~sel_oh;
		priority if (sel_oh[0]) push_data = ev_q[0];
		else if (sel_oh[1])     push_data = ev_q[1];
		else                    push_data = ev_q[2];
		push_data.last = rest == '0;
	end

	assign push = (state_q == ST_PUSH) && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= '0;
			cpu_st_q    <= '0;
			mem_st_q    <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_QUAL;
				end
				ST_QUAL: begin
					cpu_st_q    <= cpu_res.st;
					mem_st_q    <= mem_res.st;
					prev_q      <= time_q;
					have_prev_q <= 1'b1;
					pend_q      <= {gap_fire, mem_res.fire, cpu_res.fire};
					if (gap_fire || mem_res.fire || cpu_res.fire) state_q <= ST_PUSH;
					else state_q <= ST_IDLE;
				end
				ST_PUSH: begin
					if (!full) begin
						pend_q <= rest;
						if (rest == '0) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cpu_q  <= cpu_tenths;
			time_q <= sample_time_ms;
			wall_q <= wall_time_ms;
		end
		if (state_q == ST_QUAL) begin
			ev_q[0] <= qual_event(KIND_CPU, cpu_res.st);
			ev_q[1] <= qual_event(KIND_MEM, mem_res.st);
			ev_q[2] <= gap_ev;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/tanq_queue.sv
// Short event queue between the front end and the output stage.
// Register-based FIFO with a show-ahead head; uses tanq_pkg.
`default_nettype none
module tanq_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  wire tanq_pkg::event_t  push_data,
	output logic                   full,
	input  wire                    pop,
	output logic                   empty,
	output tanq_pkg::event_t       head
);
	import tanq_pkg::*;

	event_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QPTR_BITS:0]   cnt_q;

	assign full  = cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_BITS'(1);
			if (pop) rd_q <= rd_q + QPTR_BITS'(1);
			if (push && !pop) cnt_q <= cnt_q + (QPTR_BITS+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (QPTR_BITS+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

>>> hw/rtl/tanq_back.sv
// Back end: output register that drains the event queue onto the result channel.
// Uses tanq_pkg.
`default_nettype none
module tanq_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              empty,
	input  wire tanq_pkg::event_t            head,
	output logic                             pop,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [1:0]                       event_kind,
	output logic [1:0]                       event_phase,
	output logic [tanq_pkg::TIME_BITS-1:0]   event_time_ms,
	output logic [tanq_pkg::WALL_BITS-1:0]   event_wall_ms,
	output logic [tanq_pkg::VALUE_BITS-1:0]  event_value,
	output logic                             last_event
);
	import tanq_pkg::*;

	logic   valid_q;
	event_t ev_q;

	assign pop = !empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) ev_q <= head;
	end

	assign out_valid     = valid_q;
	assign event_kind    = ev_q.kind;
	assign event_phase   = ev_q.phase;
	assign event_time_ms = ev_q.time_ms;
	assign event_wall_ms = ev_q.wall_ms;
	assign event_value   = ev_q.value;
	assign last_event    = ev_q.last;

endmodule
`default_nettype wire

>>> hw/rtl/telemetry_anomaly_qualifier_top.sv
// Telemetry anomaly qualifier top level: configuration registers and the
// front end, event queue and output stage. Uses tanq_pkg, tanq_front,
// tanq_queue and tanq_back.
//
// Usage:
// Samples enter on in_valid/in_stall; an item is taken when in_valid is high
// and in_stall low. Each sample yields zero to three events (CPU, memory,
// delay, in that order) on out_valid/out_stall; last_event marks the final
// event of a sample. A sample with no event yields nothing.
// One sample is worked at a time: the bit-serial memory load divider runs,
// the qualifiers and the gap check are updated, and then the sample's events
// are pushed into the queue in order while the queue has room.
// A four-entry event queue and an output register part the front end from the
// receiver; when the receiver stalls, the queue fills, the front end holds and
// in_stall stays high. Reset clears both episodes, the run counters and the
// previous-sample time and loads the default limits. Registers are written
// over the APB port at byte addresses 0, 4, 8 and 12; the user must write them
// only while no sample is in flight, as the block itself does not enforce it.
`default_nettype none
module telemetry_anomaly_qualifier_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [tanq_pkg::PADDR_BITS-1:0]  paddr,
	input  wire  [tanq_pkg::PDATA_BITS-1:0]  pwdata,
	output logic [tanq_pkg::PDATA_BITS-1:0]  prdata,
	output logic                             pready,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [tanq_pkg::LOAD_BITS-1:0]   cpu_tenths,
	input  wire  [tanq_pkg::BYTE_BITS-1:0]   mem_used_bytes,
	input  wire  [tanq_pkg::BYTE_BITS-1:0]   mem_free_bytes,
	input  wire  [tanq_pkg::TIME_BITS-1:0]   sample_time_ms,
	input  wire  [tanq_pkg::WALL_BITS-1:0]   wall_time_ms,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [1:0]                       event_kind,
	output logic [1:0]                       event_phase,
	output logic [tanq_pkg::TIME_BITS-1:0]   event_time_ms,
	output logic [tanq_pkg::WALL_BITS-1:0]   event_wall_ms,
	output logic [tanq_pkg::VALUE_BITS-1:0]  event_value,
	output logic                             last_event
);
	import tanq_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	logic     push;
	event_t   push_data;
	logic     full;
	logic     pop;
	logic     empty;
	event_t   head;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cpu_limit   <= CPU_LIMIT_RST;
			cfg_q.mem_limit   <= MEM_LIMIT_RST;
			cfg_q.confirm     <= CONFIRM_RST;
			cfg_q.delay_limit <= DELAY_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CPU_LIMIT:   cfg_q.cpu_limit   <= pwdata[LOAD_BITS-1:0];
				REG_MEM_LIMIT:   cfg_q.mem_limit   <= pwdata[LOAD_BITS-1:0];
				REG_CONFIRM:     cfg_q.confirm     <= pwdata[COUNT_BITS-1:0];
				REG_DELAY_LIMIT: cfg_q.delay_limit <= pwdata[DELAY_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CPU_LIMIT:   prdata = PDATA_BITS'(cfg_q.cpu_limit);
			REG_MEM_LIMIT:   prdata = PDATA_BITS'(cfg_q.mem_limit);
			REG_CONFIRM:     prdata = PDATA_BITS'(cfg_q.confirm);
			REG_DELAY_LIMIT: prdata = PDATA_BITS'(cfg_q.delay_limit);
			default:         prdata = '0;
		endcase
	end

	tanq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cpu_tenths    (cpu_tenths),
		.mem_used_bytes(mem_used_bytes),
		.mem_free_bytes(mem_free_bytes),
		.sample_time_ms(sample_time_ms),
		.wall_time_ms  (wall_time_ms),
		.push          (push),
		.push_data     (push_data),
		.full          (full)
	);

	tanq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	tanq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.event_phase  (event_phase),
		.event_time_ms(event_time_ms),
		.event_wall_ms(event_wall_ms),
		.event_value  (event_value),
		.last_event   (last_event)
	);

endmodule
`default_nettype wire
